// ===== rtl/indexed_min_heap_unit_assert.svh =====
// ============================================================================
// Assertion macros for the indexed min-heap unit
// Concurrent checks are compiled in simulation only; synthesis sees empty macros.
// ============================================================================
`ifndef INDEXED_MIN_HEAP_UNIT_ASSERT_SVH
`define INDEXED_MIN_HEAP_UNIT_ASSERT_SVH
`ifndef SYNTHESIS
// Same-cycle implication, checked while out of reset.
`define IMH_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("indexed min-heap check failed");
// Next-cycle implication, checked while out of reset.
`define IMH_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("indexed min-heap check failed");
`else
`define IMH_ASSERT_NOW(label, clk, rst, ante, cons)
`define IMH_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

// ===== rtl/imh_pkg.sv =====
// ============================================================================
// Indexed min-heap package
// Field widths, opcodes and status codes shared by the heap unit files.
// ============================================================================
package imh_pkg;
   localparam int NUM_KEYS_DEF    = 1024;
   localparam int WEIGHT_BITS_DEF = 32;

   localparam int KEY_W    = 10;
   localparam int WEIGHT_W = 32;
   localparam int STATUS_W = 2;
   localparam int SIZE_W   = 11;

   localparam logic OP_SET = 1'b0;
   localparam logic OP_POP = 1'b1;

   localparam logic [STATUS_W-1:0] STAT_INSERTED = 2'd0;
   localparam logic [STATUS_W-1:0] STAT_UPDATED  = 2'd1;
   localparam logic [STATUS_W-1:0] STAT_POPPED   = 2'd2;
   localparam logic [STATUS_W-1:0] STAT_EMPTY    = 2'd3;
endpackage

// ===== rtl/imh_req_if.sv =====
// ============================================================================
// Request channel interface
// Valid/ready channel carrying one heap operation per transaction.
// ============================================================================
interface imh_req_if;
   import imh_pkg::*;
   logic                valid;
   logic                ready;
   logic                opcode;
   logic [KEY_W-1:0]    key;
   logic [WEIGHT_W-1:0] weight_value;
   modport source (output valid, opcode, key, weight_value, input ready);
   modport sink   (input valid, opcode, key, weight_value, output ready);
endinterface

// ===== rtl/imh_rsp_if.sv =====
// ============================================================================
// Response channel interface
// Valid/ready channel carrying one result per heap operation.
// ============================================================================
interface imh_rsp_if;
   import imh_pkg::*;
   logic                valid;
   logic                ready;
   logic [KEY_W-1:0]    popped_key;
   logic [WEIGHT_W-1:0] popped_weight;
   logic [STATUS_W-1:0] status;
   logic [SIZE_W-1:0]   heap_size;
   modport source (output valid, popped_key, popped_weight, status, heap_size,
                   input ready);
   modport sink   (input valid, popped_key, popped_weight, status, heap_size,
                   output ready);
endinterface

// ===== rtl/imh_ram.sv =====
// ============================================================================
// Heap unit RAM
// Simple dual-port synchronous RAM with one write port and a registered read.
// ============================================================================
module imh_ram #(
   parameter int DEPTH = 1024,
   parameter int DATA_W = 8
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [DATA_W-1:0]        wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [DATA_W-1:0]        rd_data
);
   logic [DATA_W-1:0] mem [DEPTH];
   logic [DATA_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;
endmodule

// ===== rtl/indexed_min_heap_unit.sv =====
// ============================================================================
// Indexed min-heap unit
// Binary min-heap over a bounded key space with insert, decrease/increase
// key and pop-minimum, kept in two synchronous RAMs.
// ============================================================================
//
//   Channel   Direction  Carries
//   req_chan  in         opcode, key, weight_value
//   rsp_chan  out        popped_key, popped_weight, status, heap_size
//
// One transaction is processed at a time. A set looks up the key's position,
// then climbs while the parent is heavier; an update then also descends. A pop
// reads the root and the last slot and descends from the root; a pop on an
// empty heap goes straight to the response. The shared read port of the slot
// RAM paces each sift level. After reset the key-position RAM is cleared one
// entry per cycle while req_chan.ready stays low. A stalled response is held
// in its output register and the next request is still accepted; that request
// waits in S_RESP until the register is free.
module indexed_min_heap_unit #(
   parameter int NUM_KEYS    = imh_pkg::NUM_KEYS_DEF,
   parameter int WEIGHT_BITS = imh_pkg::WEIGHT_BITS_DEF
) (
   input  logic       clock,
   input  logic       reset,
   imh_req_if.sink    req_chan,
   imh_rsp_if.source  rsp_chan
);
   import imh_pkg::*;
   `include "indexed_min_heap_unit_assert.svh"

   // Heap index width, count width and stored weight width.
   localparam int KW = $clog2(NUM_KEYS);
   localparam int CW = $clog2(NUM_KEYS + 1);
   localparam int SW = (WEIGHT_BITS < WEIGHT_W) ? WEIGHT_BITS : WEIGHT_W;
   localparam int SLOT_W = KW + SW;
   localparam int POS_W = KW + 1;
   // Reduction step for keys beyond the key space (never taken when the
   // port cannot express such a key).
   localparam int RED_STEP = (NUM_KEYS > 1023) ? 1 : NUM_KEYS;

   localparam logic [4:0] S_IDLE   = 5'd0;
   localparam logic [4:0] S_CLR    = 5'd1;
   localparam logic [4:0] S_REDUCE = 5'd2;
   localparam logic [4:0] S_LOOK   = 5'd3;
   localparam logic [4:0] S_LOOKW  = 5'd4;
   localparam logic [4:0] S_UP     = 5'd5;
   localparam logic [4:0] S_UPCMP  = 5'd6;
   localparam logic [4:0] S_UPDONE = 5'd7;
   localparam logic [4:0] S_DNL    = 5'd8;
   localparam logic [4:0] S_DNR    = 5'd9;
   localparam logic [4:0] S_DNCMP  = 5'd10;
   localparam logic [4:0] S_DNDONE = 5'd11;
   localparam logic [4:0] S_PRD0   = 5'd12;
   localparam logic [4:0] S_PRD1   = 5'd13;
   localparam logic [4:0] S_PLAST  = 5'd14;
   localparam logic [4:0] S_PCLR   = 5'd15;
   localparam logic [4:0] S_RESP   = 5'd16;

   logic [4:0]          state_ff, state_in;
   logic [KW-1:0]       clr_ff, clr_in;
   logic                op_ff, op_in;
   logic                upd_ff, upd_in;
   logic [KEY_W-1:0]    red_ff, red_in;
   logic [KW-1:0]       ekey_ff, ekey_in;   // key of the element being sifted
   logic [SW-1:0]       w_ff, w_in;         // its weight
   logic [KW-1:0]       cur_ff, cur_in;     // current hole position
   logic [CW-1:0]       count_ff, count_in;
   logic [SLOT_W-1:0]   left_ff, left_in;   // left child captured for compare
   logic [KW-1:0]       rootkey_ff, rootkey_in;
   logic [KW-1:0]       res_key_ff, res_key_in;
   logic [SW-1:0]       res_w_ff, res_w_in;
   logic [STATUS_W-1:0] res_st_ff, res_st_in;

   logic                rsp_valid_ff, rsp_valid_in;
   logic [KEY_W-1:0]    rsp_key_ff, rsp_key_in;
   logic [WEIGHT_W-1:0] rsp_w_ff, rsp_w_in;
   logic [STATUS_W-1:0] rsp_st_ff, rsp_st_in;
   logic [SIZE_W-1:0]   rsp_size_ff, rsp_size_in;

   logic                slot_we;
   logic [KW-1:0]       slot_waddr, slot_raddr;
   logic [SLOT_W-1:0]   slot_wdata, slot_rd;
   logic                pos_we;
   logic [KW-1:0]       pos_waddr, pos_raddr;
   logic [POS_W-1:0]    pos_wdata, pos_rd;

   logic [KW-1:0]       rd_key;
   logic [SW-1:0]       rd_w;
   logic [KW-1:0]       left_key;
   logic [SW-1:0]       left_w;
   logic [KW:0]         lc, rc, count_x;
   logic                rc_ok, lgo, rgo, pick_r;
   logic                req_fire, rsp_free;

   // Slot RAM holds {key, weight} per heap position so a compare needs one read.
   imh_ram #(.DEPTH(NUM_KEYS), .DATA_W(SLOT_W)) u_slot_ram (
      .clock   (clock),
      .wr_en   (slot_we),
      .wr_addr (slot_waddr),
      .wr_data (slot_wdata),
      .rd_addr (slot_raddr),
      .rd_data (slot_rd)
   );

   // Position RAM holds {present, position} per key.
   imh_ram #(.DEPTH(NUM_KEYS), .DATA_W(POS_W)) u_pos_ram (
      .clock   (clock),
      .wr_en   (pos_we),
      .wr_addr (pos_waddr),
      .wr_data (pos_wdata),
      .rd_addr (pos_raddr),
      .rd_data (pos_rd)
   );

   assign rd_key   = slot_rd[SW +: KW];
   assign rd_w     = slot_rd[SW-1:0];
   assign left_key = left_ff[SW +: KW];
   assign left_w   = left_ff[SW-1:0];
   assign lc       = {cur_ff, 1'b1};
   assign rc       = lc + (KW+1)'(1);
   assign count_x  = (KW+1)'(count_ff);
   assign rc_ok    = rc < count_x;
   assign lgo      = w_ff > left_w;
   assign rgo      = rc_ok && (w_ff > rd_w);
   assign pick_r   = rc_ok && (rd_w <= left_w);

   assign req_chan.ready = (state_ff == S_IDLE);
   assign req_fire       = req_chan.valid && (state_ff == S_IDLE);
   assign rsp_free       = !rsp_valid_ff || rsp_chan.ready;

   always_comb begin
      state_in     = state_ff;
      clr_in       = clr_ff;
      op_in        = op_ff;
      upd_in       = upd_ff;
      red_in       = red_ff;
      ekey_in      = ekey_ff;
      w_in         = w_ff;
      cur_in       = cur_ff;
      count_in     = count_ff;
      left_in      = left_ff;
      rootkey_in   = rootkey_ff;
      res_key_in   = res_key_ff;
      res_w_in     = res_w_ff;
      res_st_in    = res_st_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_key_in   = rsp_key_ff;
      rsp_w_in     = rsp_w_ff;
      rsp_st_in    = rsp_st_ff;
      rsp_size_in  = rsp_size_ff;

      slot_we    = 1'b0;
      slot_waddr = cur_ff;
      slot_wdata = {ekey_ff, w_ff};
      slot_raddr = '0;
      pos_we     = 1'b0;
      pos_waddr  = ekey_ff;
      pos_wdata  = {1'b1, cur_ff};
      pos_raddr  = ekey_ff;

      if (rsp_valid_ff && rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         S_CLR: begin
            pos_we    = 1'b1;
            pos_waddr = clr_ff;
            pos_wdata = '0;
            clr_in    = clr_ff + KW'(1);
            if (clr_ff == KW'(NUM_KEYS - 1)) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (req_fire) begin
               op_in      = req_chan.opcode;
               red_in     = req_chan.key;
               w_in       = SW'(req_chan.weight_value);
               res_key_in = '0;
               res_w_in   = '0;
               if (req_chan.opcode == OP_POP) begin
                  if (count_ff == '0) begin
                     res_st_in = STAT_EMPTY;
                     state_in  = S_RESP;
                  end else begin
                     state_in = S_PRD0;
                  end
               end else begin
                  state_in = S_REDUCE;
               end
            end
         end
         S_REDUCE: begin
            if (32'(red_ff) >= NUM_KEYS) begin
               red_in = red_ff - KEY_W'(RED_STEP);
            end else begin
               ekey_in  = KW'(red_ff);
               state_in = S_LOOK;
            end
         end
         S_LOOK: begin
            state_in = S_LOOKW;
         end
         S_LOOKW: begin
            if (pos_rd[KW]) begin
               upd_in    = 1'b1;
               cur_in    = pos_rd[KW-1:0];
               res_st_in = STAT_UPDATED;
            end else begin
               upd_in    = 1'b0;
               cur_in    = KW'(count_ff);
               count_in  = count_ff + CW'(1);
               res_st_in = STAT_INSERTED;
            end
            state_in = S_UP;
         end
         S_UP: begin
            slot_raddr = (cur_ff - KW'(1)) >> 1;
            state_in   = (cur_ff == '0) ? S_UPDONE : S_UPCMP;
         end
         S_UPCMP: begin
            // Parent strictly heavier: move it down into the hole.
            if (rd_w > w_ff) begin
               slot_we    = 1'b1;
               slot_wdata = slot_rd;
               pos_we     = 1'b1;
               pos_waddr  = rd_key;
               cur_in     = (cur_ff - KW'(1)) >> 1;
               state_in   = S_UP;
            end else begin
               state_in = S_UPDONE;
            end
         end
         S_UPDONE: begin
            slot_we  = 1'b1;
            pos_we   = 1'b1;
            state_in = upd_ff ? S_DNL : S_RESP;
         end
         S_DNL: begin
            slot_raddr = lc[KW-1:0];
            state_in   = (lc >= count_x) ? S_DNDONE : S_DNR;
         end
         S_DNR: begin
            left_in    = slot_rd;
            slot_raddr = rc[KW-1:0];
            state_in   = S_DNCMP;
         end
         S_DNCMP: begin
            // Right child wins ties against the left one.
            if (!lgo && !rgo) begin
               state_in = S_DNDONE;
            end else begin
               slot_we    = 1'b1;
               slot_wdata = pick_r ? slot_rd : left_ff;
               pos_we     = 1'b1;
               pos_waddr  = pick_r ? rd_key : left_key;
               cur_in     = pick_r ? rc[KW-1:0] : lc[KW-1:0];
               state_in   = S_DNL;
            end
         end
         S_DNDONE: begin
            slot_we  = 1'b1;
            pos_we   = 1'b1;
            state_in = (op_ff == OP_POP) ? S_PCLR : S_RESP;
         end
         S_PRD0: begin
            slot_raddr = '0;
            state_in   = S_PRD1;
         end
         S_PRD1: begin
            res_key_in = rd_key;
            res_w_in   = rd_w;
            rootkey_in = rd_key;
            slot_raddr = KW'(count_ff - CW'(1));
            state_in   = S_PLAST;
         end
         S_PLAST: begin
            ekey_in   = rd_key;
            w_in      = rd_w;
            count_in  = count_ff - CW'(1);
            cur_in    = '0;
            res_st_in = STAT_POPPED;
            state_in  = S_DNL;
         end
         S_PCLR: begin
            // The popped key is marked absent last, after the re-placement.
            pos_we    = 1'b1;
            pos_waddr = rootkey_ff;
            pos_wdata = '0;
            state_in  = S_RESP;
         end
         S_RESP: begin
            if (rsp_free) begin
               rsp_valid_in = 1'b1;
               rsp_key_in   = KEY_W'(res_key_ff);
               rsp_w_in     = WEIGHT_W'(res_w_ff);
               rsp_st_in    = res_st_ff;
               rsp_size_in  = SIZE_W'(count_ff);
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLR;
         clr_ff       <= '0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
         op_ff        <= OP_SET;
         upd_ff       <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
         op_ff        <= op_in;
         upd_ff       <= upd_in;
      end
      red_ff      <= red_in;
      ekey_ff     <= ekey_in;
      w_ff        <= w_in;
      cur_ff      <= cur_in;
      left_ff     <= left_in;
      rootkey_ff  <= rootkey_in;
      res_key_ff  <= res_key_in;
      res_w_ff    <= res_w_in;
      res_st_ff   <= res_st_in;
      rsp_key_ff  <= rsp_key_in;
      rsp_w_ff    <= rsp_w_in;
      rsp_st_ff   <= rsp_st_in;
      rsp_size_ff <= rsp_size_in;
   end

   assign rsp_chan.valid         = rsp_valid_ff;
   assign rsp_chan.popped_key    = rsp_key_ff;
   assign rsp_chan.popped_weight = rsp_w_ff;
   assign rsp_chan.status        = rsp_st_ff;
   assign rsp_chan.heap_size     = rsp_size_ff;

   // The heap never holds more keys than the key space.
   `IMH_ASSERT_NOW(a_count_bound, clock, reset, 1'b1, 32'(count_ff) <= NUM_KEYS)
   // The parent compare is only reached from a non-root position.
   `IMH_ASSERT_NOW(a_up_not_root, clock, reset, state_ff == S_UPCMP, cur_ff != '0)
   // An empty-pop result is only produced while the heap is empty.
   `IMH_ASSERT_NEXT(a_empty_status, clock, reset,
      state_ff == S_RESP && rsp_free && res_st_ff == STAT_EMPTY, count_ff == '0)
endmodule

// ===== verif/imh_heap_checker.sv =====
// ----------------------------------------------------------------------------
// Indexed min-heap checker
// Watches both channels, keeps its own copy of the heap and compares results.
// ----------------------------------------------------------------------------
module imh_heap_checker (
   input  logic   clock,
   input  logic   reset,
   imh_req_if     req_chan,
   imh_rsp_if     rsp_chan,
   output int     fail_count,
   output int     pending_count
);
   timeunit 1ns;
   timeprecision 1ps;
   import imh_pkg::*;

   typedef struct packed {
      logic [KEY_W-1:0]    popped_key;
      logic [WEIGHT_W-1:0] popped_weight;
      logic [STATUS_W-1:0] status;
      logic [SIZE_W-1:0]   heap_size;
   } heap_result_type;

   logic [KEY_W-1:0]    slot_key [NUM_KEYS_DEF];
   logic [SIZE_W-1:0]   key_slot [NUM_KEYS_DEF];
   bit                  key_held [NUM_KEYS_DEF];
   logic [WEIGHT_W-1:0] key_wt   [NUM_KEYS_DEF];
   int unsigned         held_count;
   heap_result_type     expected_results[$];

   function automatic logic [WEIGHT_W-1:0] wt_at(int unsigned pos);
      return key_wt[slot_key[pos]];
   endfunction

   function automatic void swap_slots(int unsigned a, int unsigned b);
      logic [KEY_W-1:0] t;
      t = slot_key[a];
      slot_key[a] = slot_key[b];
      slot_key[b] = t;
      key_slot[slot_key[a]] = SIZE_W'(a);
      key_slot[slot_key[b]] = SIZE_W'(b);
   endfunction

   function automatic void climb(int unsigned pos);
      int unsigned up;
      while (pos > 0) begin
         up = (pos - 1) / 2;
         if (!(wt_at(up) > wt_at(pos))) break;
         swap_slots(pos, up);
         pos = up;
      end
   endfunction

   function automatic void descend(int unsigned pos);
      int unsigned lc, rc, pick;
      bit lgo, rgo;
      forever begin
         lc = 2 * pos + 1;
         rc = 2 * pos + 2;
         lgo = lc < held_count && wt_at(pos) > wt_at(lc);
         rgo = rc < held_count && wt_at(pos) > wt_at(rc);
         if (!lgo && !rgo) break;
         pick = (rc < held_count && wt_at(rc) <= wt_at(lc)) ? rc : lc;
         swap_slots(pos, pick);
         pos = pick;
      end
   endfunction

   function automatic heap_result_type apply_op(logic op, logic [KEY_W-1:0] k,
                                                 logic [WEIGHT_W-1:0] w);
      heap_result_type r;
      logic [KEY_W-1:0] top;
      r = '0;
      if (op == OP_SET) begin
         if (!key_held[k]) begin
            slot_key[held_count] = k;
            key_slot[k] = SIZE_W'(held_count);
            key_held[k] = 1;
            key_wt[k] = w;
            held_count++;
            climb(held_count - 1);
            r.status = STAT_INSERTED;
         end else begin
            key_wt[k] = w;
            climb(key_slot[k]);
            descend(key_slot[k]);
            r.status = STAT_UPDATED;
         end
      end else if (held_count == 0) begin
         r.status = STAT_EMPTY;
      end else begin
         top = slot_key[0];
         r.popped_key = top;
         r.popped_weight = key_wt[top];
         swap_slots(0, held_count - 1);
         held_count--;
         descend(0);
         key_held[top] = 0;
         r.status = STAT_POPPED;
      end
      r.heap_size = SIZE_W'(held_count);
      return r;
   endfunction

   heap_result_type got, want;

   always @(posedge clock) begin
      if (reset) begin
         held_count = 0;
         foreach (key_held[i]) key_held[i] = 0;
         expected_results.delete();
         fail_count <= 0;
         pending_count <= 0;
      end else begin
         if (req_chan.valid && req_chan.ready)
            expected_results.push_back(apply_op(req_chan.opcode, req_chan.key,
                                                req_chan.weight_value));
         if (rsp_chan.valid && rsp_chan.ready) begin
            got = '{rsp_chan.popped_key, rsp_chan.popped_weight, rsp_chan.status,
                    rsp_chan.heap_size};
            if (expected_results.size() == 0) begin
               $display("%0t: unexpected transaction, actual %p", $time, got);
               fail_count <= fail_count + 1;
            end else begin
               want = expected_results.pop_front();
               if (got !== want) begin
                  $display("%0t: mismatch, expected %p actual %p", $time, want, got);
                  fail_count <= fail_count + 1;
               end
            end
         end
         // Counted as the queue stands after this edge's pushes and pops.
         pending_count <= expected_results.size();
      end
   end
endmodule

// ===== verif/tb_top.sv =====
// ----------------------------------------------------------------------------
// Indexed min-heap unit testbench
// Drives set and pop transactions with random gaps and stalls; a checker
// beside the block predicts every response and counts mismatches.
// ----------------------------------------------------------------------------
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;
   import imh_pkg::*;

   logic clock = 0;
   logic reset = 1;
   int   fail_count, pending_count;

   imh_req_if req_chan();
   imh_rsp_if rsp_chan();

   indexed_min_heap_unit dut (.clock(clock), .reset(reset),
                              .req_chan(req_chan), .rsp_chan(rsp_chan));

   imh_heap_checker checker_i (.clock(clock), .reset(reset), .req_chan(req_chan),
                               .rsp_chan(rsp_chan), .fail_count(fail_count),
                               .pending_count(pending_count));

   always begin
      #6 clock = 1;
      #6 clock = 0;
   end

   // Most gaps are short; now and then a long one.
   function automatic int gap_len();
      int r;
      r = $urandom_range(0, 99);
      if (r < 50) return 0;
      if (r < 90) return $urandom_range(1, 3);
      return $urandom_range(10, 60);
   endfunction

   // The response side stalls at random, with calm stretches in between.
   initial begin
      int n;
      rsp_chan.ready <= 0;
      forever begin
         n = gap_len();
         repeat (n) begin
            @(posedge clock);
            rsp_chan.ready <= 0;
         end
         n = $urandom_range(1, 40);
         repeat (n) begin
            @(posedge clock);
            rsp_chan.ready <= 1;
         end
      end
   end

   // Offers one transaction and holds it until the block takes it. Valid is
   // lowered only after acceptance and only when a gap or a drain follows.
   task automatic send_op(logic op, logic [KEY_W-1:0] k, logic [WEIGHT_W-1:0] w);
      int g;
      g = gap_len();
      if (g > 0) begin
         req_chan.valid <= 0;
         repeat (g) @(posedge clock);
      end else if (!req_chan.valid) begin
         @(posedge clock);
      end
      req_chan.valid <= 1;
      req_chan.opcode <= op;
      req_chan.key <= k;
      req_chan.weight_value <= w;
      do @(posedge clock); while (!req_chan.ready);
   endtask

   task automatic drain();
      req_chan.valid <= 0;
      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
   endtask

   function automatic logic [WEIGHT_W-1:0] rand_weight();
      case ($urandom_range(0, 3))
         0: return $urandom_range(0, 15);   // many ties
         1: return 32'hFFFF_FFF0 | $urandom_range(0, 15);
         default: return $urandom;
      endcase
   endfunction

   initial begin
      int i, phase, key_span;
      req_chan.valid <= 0;
      req_chan.opcode <= OP_SET;
      req_chan.key <= '0;
      req_chan.weight_value <= '0;
      repeat (12) @(posedge clock);
      reset <= 0;

      // Directed: pop on empty heap, extreme keys and weights, ties, updates
      // both lighter and heavier, and pops down to empty again.
      send_op(OP_POP, '1, '1);
      send_op(OP_SET, 10'd0, 32'hFFFF_FFFF);
      send_op(OP_SET, 10'd1023, 32'd0);
      send_op(OP_SET, 10'd512, 32'd0);
      send_op(OP_SET, 10'd341, 32'd7);
      send_op(OP_SET, 10'd682, 32'd7);
      send_op(OP_SET, 10'd0, 32'd3);
      send_op(OP_SET, 10'd1023, 32'hFFFF_FFFF);
      send_op(OP_SET, 10'd341, 32'd7);
      send_op(OP_SET, 10'd5, 32'h8000_0000);
      send_op(OP_POP, 10'd0, 32'd0);
      send_op(OP_POP, 10'h2AA, 32'h5555_5555);
      send_op(OP_SET, 10'd512, 32'd1);
      for (i = 0; i < 6; i++) send_op(OP_POP, '0, '0);
      send_op(OP_POP, '0, '0);
      drain();

      // Random phases: narrow key ranges give many updates. One phase fills
      // the heap completely and then pops part of it, so later phases work on
      // a deep heap.
      for (phase = 0; phase < 6; phase++) begin
         key_span = (phase == 0) ? 15 : (phase == 5) ? 1023 : $urandom_range(31, 255);
         if (phase == 1) begin
            for (i = 0; i < 1024; i++) send_op(OP_SET, 10'(i), rand_weight());
            for (i = 0; i < 200; i++) send_op(OP_POP, '0, '0);
         end else begin
            for (i = 0; i < 80; i++) begin
               if ($urandom_range(0, 99) < 60)
                  send_op(OP_SET, 10'($urandom_range(0, key_span)), rand_weight());
               else
                  send_op(OP_POP, 10'($urandom), $urandom);
            end
         end
         drain();
      end

      repeat (100) @(posedge clock);
      if (fail_count == 0 && pending_count == 0)
         $display("** indexed_min_heap_unit: PASSED **");
      else
         $display("** indexed_min_heap_unit: FAILED **");
      $finish;
   end

   initial begin
      #20ms;
      $display("** indexed_min_heap_unit: FAILED **");
      $finish;
   end
endmodule

// ===== filelist.f =====
+incdir+rtl
rtl/imh_pkg.sv
rtl/imh_req_if.sv
rtl/imh_rsp_if.sv
rtl/imh_ram.sv
rtl/indexed_min_heap_unit.sv
verif/imh_heap_checker.sv
verif/tb_top.sv
